// ----- rtl/mbps_pkg.sv -----
// Shared constants, codes and types of the masked byte pattern scanner.
`timescale 1ns / 1ps
package mbps_pkg;

    localparam int unsigned PATTERN_BYTES = 16;
    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned ADDR_W        = 32;
    localparam int unsigned WORD_W        = 32;
    localparam int unsigned LEN_W         = 5;
    localparam int unsigned MODE_W        = 3;
    localparam int unsigned CFG_IDX_W     = 3;
    localparam int unsigned CFG_DATA_W    = 64;
    localparam int unsigned PATTERN_W     = PATTERN_BYTES * BYTE_W;

    localparam logic [ADDR_W-1:0] RESET_SCAN_START = 32'h0040_0000;
    localparam logic [ADDR_W-1:0] RESET_SCAN_END   = 32'h0200_0000;

    // Offsets added to a relative branch displacement.
    localparam logic [WORD_W-1:0] REL_AT1_BIAS = 32'd5;
    localparam logic [WORD_W-1:0] REL_AT2_BIAS = 32'd6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW    = 3'd0,
        CFG_PATTERN_HIGH   = 3'd1,
        CFG_WILDCARD_MASK  = 3'd2,
        CFG_PATTERN_LENGTH = 3'd3,
        CFG_SCAN_START     = 3'd4,
        CFG_SCAN_END       = 3'd5,
        CFG_RESULT_MODE    = 3'd6
    } t_cfg_index;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADDRESS = 3'd0,
        MODE_REL_AT1 = 3'd1,
        MODE_REL_AT2 = 3'd2,
        MODE_ABS_AT1 = 3'd3,
        MODE_ABS_AT2 = 3'd4
    } t_result_mode;

    // What the intake stage knows about one byte beat.
    typedef struct packed {
        logic              judge;
        logic              last;
        logic              in_range;
        logic [ADDR_W-1:0] addr;
    } t_intake;

endpackage

// ----- rtl/mbps_channels.sv -----
// Valid/ready channel interfaces for the byte stream and the result stream.
`timescale 1ns / 1ps
interface mbps_in_if;
    import mbps_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mbps_out_if;
    import mbps_pkg::*;

    logic              valid;
    logic              ready;
    logic              found;
    logic [ADDR_W-1:0] match_address;
    logic [WORD_W-1:0] result_value;

    modport source (output valid, output found, output match_address,
                    output result_value, input ready);
    modport sink   (input valid, input found, input match_address,
                    input result_value, output ready);
endinterface

// ----- rtl/mbps_cell.sv -----
// One window cell: holds a byte, passes it to its lower neighbor, compares it.
`timescale 1ns / 1ps
module mbps_cell (
    input  logic                        i_clk,
    input  logic                        i_shift,
    input  logic [mbps_pkg::BYTE_W-1:0] i_byte,
    input  logic [mbps_pkg::BYTE_W-1:0] i_pattern,
    input  logic                        i_care,
    output logic [mbps_pkg::BYTE_W-1:0] o_byte,
    output logic                        o_match
);
    import mbps_pkg::*;

    logic [BYTE_W-1:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte  = r_byte;
    // A cell outside the pattern length or under a wildcard always matches.
    assign o_match = !i_care || (r_byte == i_pattern);

endmodule

// ----- rtl/masked_byte_pattern_scanner.sv -----
// Top level of the masked byte pattern scanner: config, cell chain and result stage.
`timescale 1ns / 1ps
// Usage
// The byte stream arrives on i_in, one byte per beat, with last_byte set on
// the final beat of a stream. The first byte of each stream lies at address
// scan_start. Results leave on o_out: at most one beat per stream, either the
// first match whose start lies below scan_end (found = 1) or, on the last
// byte, a not-found beat with all fields zero.
// Configuration is written through i_cfg_we, i_cfg_index and i_cfg_data; the
// user must write it only while the block is idle, which the block does not
// enforce. Register indexes follow the order of the register list. Throughput is
// one byte per cycle unless a waiting result stalls i_in: the cell chain shifts
// on every accepted beat and the sixteen byte compares run in parallel in the
// cells. An accepted byte updates the window and the intake register, which load
// the result register. The result register and the intake stage each hold one
// beat, so one more byte is taken while a result waits; after that i_in.ready
// follows o_out.ready. Synchronous reset clears the counters, the pipeline valids
// and the configuration registers to their reset values; the window bytes are
// not cleared, since no position is judged before sixteen bytes have arrived.
module masked_byte_pattern_scanner (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mbps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    mbps_in_if.sink                         i_in,
    mbps_out_if.source                      o_out
);
    import mbps_pkg::*;

    // Configuration registers.
    logic [63:0]        r_pattern_low;
    logic [63:0]        r_pattern_high;
    logic [PATTERN_BYTES-1:0] r_wildcard_mask;
    logic [LEN_W-1:0]   r_pattern_length;
    logic [ADDR_W-1:0]  r_scan_start;
    logic [ADDR_W-1:0]  r_scan_end;
    logic [MODE_W-1:0]  r_result_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_low    <= '0;
            r_pattern_high   <= '0;
            r_wildcard_mask  <= '0;
            r_pattern_length <= '0;
            r_scan_start     <= RESET_SCAN_START;
            r_scan_end       <= RESET_SCAN_END;
            r_result_mode    <= MODE_ADDRESS;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_PATTERN_LOW:    r_pattern_low    <= i_cfg_data;
                CFG_PATTERN_HIGH:   r_pattern_high   <= i_cfg_data;
                CFG_WILDCARD_MASK:  r_wildcard_mask  <= i_cfg_data[PATTERN_BYTES-1:0];
                CFG_PATTERN_LENGTH: r_pattern_length <= i_cfg_data[LEN_W-1:0];
                CFG_SCAN_START:     r_scan_start     <= i_cfg_data[ADDR_W-1:0];
                CFG_SCAN_END:       r_scan_end       <= i_cfg_data[ADDR_W-1:0];
                CFG_RESULT_MODE:    r_result_mode    <= i_cfg_data[MODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    logic [PATTERN_W-1:0] w_pattern;
    assign w_pattern = {r_pattern_high, r_pattern_low};

    // Handshake and pipeline control.
    logic    w_accept;
    logic    w_out_free;
    logic    w_adv;
    logic    r_a_valid;
    t_intake r_a;

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !o_out.valid || o_out.ready;
    assign w_adv      = r_a_valid && w_out_free;
    assign i_in.ready = !r_a_valid || w_adv;

    // Cell chain: the newest byte enters the top cell, cell zero holds the
    // oldest byte of the window, which is the start of the judged position.
    logic [BYTE_W-1:0]        w_win [PATTERN_BYTES];
    logic [PATTERN_BYTES-1:0] w_match;

    for (genvar g = 0; g < PATTERN_BYTES; g++) begin : g_cell
        logic [BYTE_W-1:0] w_feed;
        logic              w_care;

        if (g == PATTERN_BYTES - 1) begin : g_top
            assign w_feed = i_in.data_byte;
        end else begin : g_inner
            assign w_feed = w_win[g+1];
        end

        assign w_care = !r_wildcard_mask[g] && (LEN_W'(g) < r_pattern_length);

        mbps_cell u_cell (
            .i_clk     (i_clk),
            .i_shift   (w_accept),
            .i_byte    (w_feed),
            .i_pattern (w_pattern[g*BYTE_W +: BYTE_W]),
            .i_care    (w_care),
            .o_byte    (w_win[g]),
            .o_match   (w_match[g])
        );
    end

    // Intake stage: count bytes and work out the start address of the
    // position that this byte completes.
    logic [ADDR_W-1:0] r_bytes_seen;
    logic [ADDR_W-1:0] w_seen_next;
    logic [ADDR_W-1:0] w_offset;
    logic [ADDR_W-1:0] w_span;
    t_intake           w_intake;

    assign w_seen_next = (r_bytes_seen == '1) ? r_bytes_seen : r_bytes_seen + 1'b1;
    assign w_offset    = w_seen_next - ADDR_W'(PATTERN_BYTES);
    assign w_span      = r_scan_end - r_scan_start;

    always_comb begin
        w_intake.judge    = w_seen_next >= ADDR_W'(PATTERN_BYTES);
        w_intake.last     = i_in.last_byte;
        w_intake.in_range = (r_scan_start < r_scan_end) && (w_offset < w_span);
        w_intake.addr     = r_scan_start + w_offset;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_seen <= '0;
            r_a_valid    <= 1'b0;
        end else begin
            if (w_accept) begin
                r_bytes_seen <= i_in.last_byte ? '0 : w_seen_next;
                r_a_valid    <= 1'b1;
            end else if (w_adv) begin
                r_a_valid    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a <= w_intake;
        end
    end

    // Result stage: the window now holds the bytes of the judged position.
    logic              r_done;
    logic              w_hit;
    logic              w_not_found;
    logic [WORD_W-1:0] w_word_at1;
    logic [WORD_W-1:0] w_word_at2;
    logic [WORD_W-1:0] w_value;

    assign w_hit       = !r_done && r_a.judge && r_a.in_range && (&w_match);
    assign w_not_found = r_a.last && !r_done && !w_hit;
    assign w_word_at1  = {w_win[4], w_win[3], w_win[2], w_win[1]};
    assign w_word_at2  = {w_win[5], w_win[4], w_win[3], w_win[2]};

    always_comb begin
        case (t_result_mode'(r_result_mode))
            MODE_REL_AT1: w_value = w_word_at1 + r_a.addr + REL_AT1_BIAS;
            MODE_REL_AT2: w_value = w_word_at2 + r_a.addr + REL_AT2_BIAS;
            MODE_ABS_AT1: w_value = w_word_at1;
            MODE_ABS_AT2: w_value = w_word_at2;
            default:      w_value = r_a.addr;
        endcase
    end

    logic              r_out_valid;
    logic              r_found;
    logic [ADDR_W-1:0] r_match_address;
    logic [WORD_W-1:0] r_result_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_done <= r_a.last ? 1'b0 : (r_done || w_hit);
            end
            if (w_adv && (w_hit || w_not_found)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && (w_hit || w_not_found)) begin
            r_found         <= w_hit;
            r_match_address <= w_hit ? r_a.addr : '0;
            r_result_value  <= w_hit ? w_value : '0;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.found         = r_found;
    assign o_out.match_address = r_match_address;
    assign o_out.result_value  = r_result_value;

endmodule
